// File: design/cbe_pkg.sv
// shared types, constants and helper functions of the cubic bezier evaluator
`default_nettype none

package cbe_pkg;

  // field widths
  localparam int T_W      = 17;
  localparam int ACT_W    = 2;
  localparam int REG_W    = 32;
  localparam int OUT_W    = 48;
  localparam int CFG_NUM  = 8;
  localparam int CFG_IDX_W = 3;

  // datapath widths
  localparam int SQ_W     = 2 * T_W;          // t*t, t*u, u*u
  localparam int CUBE_W   = SQ_W + T_W;       // third-order products
  localparam int WGT_W    = CUBE_W - 24;      // rounded Q0.24 weights
  localparam int DW_W     = SQ_W + 2;         // 3*u^2 + 128 and friends
  localparam int COEF_W   = 30;
  localparam int PROD_W   = COEF_W + REG_W;
  localparam int SAB_W    = PROD_W + 1;
  localparam int SUM_W    = 66;

  // divide by five, eight quotient bits per stage
  localparam int DIV_STEP   = 8;
  localparam int DIV_STAGES = 6;
  localparam int MQ_W       = DIV_STEP * DIV_STAGES;
  localparam int REM_W      = 3;
  localparam int QOFS_BIT   = 38;

  // pipeline stage counts
  localparam int AXIS_STG = 3 + DIV_STAGES;
  localparam int NSTG     = 4 + AXIS_STG;

  localparam logic [T_W-1:0]    ONE_Q16 = T_W'(65536);
  localparam logic [CUBE_W-1:0] RND24   = CUBE_W'(1) << 23;
  localparam logic [DW_W-1:0]   RND8    = DW_W'(128);
  // half of 5*2^24 for rounding, plus 5*2^62 so the sum never goes negative
  localparam logic [SUM_W-1:0]  SUM_OFS = (SUM_W'(5) << 62) | (SUM_W'(5) << 23);
  localparam logic [REM_W:0]    DIVISOR = (REM_W + 1)'(5);

  typedef enum logic [ACT_W-1:0] {
    ACT_POINT  = 2'd0,
    ACT_DERIV1 = 2'd1,
    ACT_DERIV2 = 2'd2
  } act_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X     = 3'd0,
    CFG_START_Y     = 3'd1,
    CFG_END_X       = 3'd2,
    CFG_END_Y       = 3'd3,
    CFG_START_TAN_X = 3'd4,
    CFG_START_TAN_Y = 3'd5,
    CFG_END_TAN_X   = 3'd6,
    CFG_END_TAN_Y   = 3'd7
  } cfg_idx_t;

  // s = 5*(a*p0 + b*p3) + c*ts + d*te
  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
  } coef_t;

  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [DIV_STEP-1:0] q;
  } div_step_t;

  // restoring division by five over one group of numerator bits
  function automatic div_step_t div5_step(logic [REM_W-1:0] rem_in,
                                          logic [DIV_STEP-1:0] bits);
    logic [REM_W:0] acc;
    logic [REM_W-1:0] rem;
    div_step_t res;
    rem = rem_in;
    res = '0;
    for (int i = DIV_STEP - 1; i >= 0; i--) begin
      acc = {rem, bits[i]};
      if (acc >= DIVISOR) begin
        res.q[i] = 1'b1;
        rem = REM_W'(acc - DIVISOR);
      end else begin
        rem = acc[REM_W-1:0];
      end
    end
    res.rem = rem;
    return res;
  endfunction

endpackage

`default_nettype wire

// File: design/cbe_if.sv
// valid/ready channel interfaces for parameter items and result items
`default_nettype none

interface cbe_in_if;
  logic                       valid;
  logic                       ready;
  logic [cbe_pkg::T_W-1:0]    t_param;
  logic [cbe_pkg::ACT_W-1:0]  action;

  modport source (output valid, output t_param, output action, input ready);
  modport sink   (input valid, input t_param, input action, output ready);
endinterface

interface cbe_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cbe_pkg::OUT_W-1:0] out_x;
  logic signed [cbe_pkg::OUT_W-1:0] out_y;

  modport source (output valid, output out_x, output out_y, input ready);
  modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

`default_nettype wire

// File: design/cbe_axis.sv
// one coordinate axis: coefficient products, sum, rounding and divide by five
`default_nettype none

module cbe_axis (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire cbe_pkg::coef_t                      coef,
  input  wire logic signed [cbe_pkg::REG_W-1:0]    p0,
  input  wire logic signed [cbe_pkg::REG_W-1:0]    p3,
  input  wire logic signed [cbe_pkg::REG_W-1:0]    ts,
  input  wire logic signed [cbe_pkg::REG_W-1:0]    te,
  output logic signed [cbe_pkg::OUT_W-1:0]         res
);

  // products
  logic signed [cbe_pkg::PROD_W-1:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [cbe_pkg::PROD_W-1:0] pa_nxt, pb_nxt, pc_nxt, pd_nxt;
  // partial sums
  logic signed [cbe_pkg::SAB_W-1:0]  sab_r, sab_nxt;
  logic [cbe_pkg::SUM_W-1:0]         scd_r, scd_nxt;
  // offset numerator, and the same divided by 2^24
  logic [cbe_pkg::SUM_W-1:0]         sum_all;
  logic [cbe_pkg::MQ_W-1:0]          m_r, m_nxt;
  // divide by five
  logic [cbe_pkg::MQ_W-1:0]          word_r   [cbe_pkg::DIV_STAGES];
  logic [cbe_pkg::MQ_W-1:0]          word_nxt [cbe_pkg::DIV_STAGES];
  logic [cbe_pkg::REM_W-1:0]         rem_r    [cbe_pkg::DIV_STAGES];
  logic [cbe_pkg::REM_W-1:0]         rem_nxt  [cbe_pkg::DIV_STAGES];
  logic [cbe_pkg::MQ_W-1:0]          quo;

  assign pa_nxt = cbe_pkg::PROD_W'($signed(coef.a)) * cbe_pkg::PROD_W'(p0);
  assign pb_nxt = cbe_pkg::PROD_W'($signed(coef.b)) * cbe_pkg::PROD_W'(p3);
  assign pc_nxt = cbe_pkg::PROD_W'($signed(coef.c)) * cbe_pkg::PROD_W'(ts);
  assign pd_nxt = cbe_pkg::PROD_W'($signed(coef.d)) * cbe_pkg::PROD_W'(te);

  assign sab_nxt = cbe_pkg::SAB_W'(pa_r) + cbe_pkg::SAB_W'(pb_r);
  assign scd_nxt = cbe_pkg::SUM_W'(pc_r) + cbe_pkg::SUM_W'(pd_r) + cbe_pkg::SUM_OFS;

  // 5*sab + scd, always non-negative thanks to the offset
  assign sum_all = (cbe_pkg::SUM_W'(sab_r) << 2) + cbe_pkg::SUM_W'(sab_r) + scd_r;
  assign m_nxt   = cbe_pkg::MQ_W'(sum_all[cbe_pkg::SUM_W-1:24]);

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= pa_nxt;
      pb_r  <= pb_nxt;
      pc_r  <= pc_nxt;
      pd_r  <= pd_nxt;
      sab_r <= sab_nxt;
      scd_r <= scd_nxt;
      m_r   <= m_nxt;
    end
  end

  for (genvar k = 0; k < cbe_pkg::DIV_STAGES; k++) begin : g_div
    logic [cbe_pkg::MQ_W-1:0]  word_in;
    logic [cbe_pkg::REM_W-1:0] rem_in;
    cbe_pkg::div_step_t        step;

    if (k == 0) begin : g_first
      assign word_in = m_r;
      assign rem_in  = '0;
    end else begin : g_rest
      assign word_in = word_r[k-1];
      assign rem_in  = rem_r[k-1];
    end

    assign step = cbe_pkg::div5_step(rem_in,
                    word_in[cbe_pkg::MQ_W-1 -: cbe_pkg::DIV_STEP]);
    // numerator bits leave at the top, quotient bits enter at the bottom
    assign word_nxt[k] = {word_in[cbe_pkg::MQ_W-cbe_pkg::DIV_STEP-1:0], step.q};
    assign rem_nxt[k]  = step.rem;

    always_ff @(posedge clk) begin
      if (en) begin
        word_r[k] <= word_nxt[k];
        rem_r[k]  <= rem_nxt[k];
      end
    end
  end

  // remove the 2^38 quotient offset: flip that bit and sign-extend from it
  assign quo = word_r[cbe_pkg::DIV_STAGES-1];
  assign res = {{(cbe_pkg::OUT_W - cbe_pkg::QOFS_BIT){~quo[cbe_pkg::QOFS_BIT]}},
                quo[cbe_pkg::QOFS_BIT-1:0]};

endmodule

`default_nettype wire

// File: design/cubic_bezier_eval_2d_unit.sv
// top level of the 2d cubic bezier point and derivative evaluator
//
//   channel   direction  handshake            payload
//   in_ch     sink       valid / ready        t_param[16:0], action[1:0]
//   out_ch    source     valid / ready        out_x[47:0], out_y[47:0] signed
//   cfg_*     sink       cfg_we, no stall     cfg_idx[2:0], cfg_wdata[31:0]
//
// one item per cycle sustained while the output is not stalled
// the pipeline is made of the clamp (1 stage), the squaring/cube multipliers
//   (2 stages), the coefficient select (1 stage), the coefficient products
//   and sum (3 stages) and the divide by five (6 stages of 8 bits)
// all stages advance together when the output register is empty or taken,
//   so a stalled output freezes the pipe and in_ch.ready drops with it
// synchronous active-low reset clears valid bits and the eight registers
`default_nettype none

module cubic_bezier_eval_2d_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [cbe_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [cbe_pkg::REG_W-1:0]       cfg_wdata,
  cbe_in_if.sink                               in_ch,
  cbe_out_if.source                            out_ch
);

  // configuration registers, each read at a fixed place
  logic signed [cbe_pkg::REG_W-1:0] cfg_r [cbe_pkg::CFG_NUM];

  // pipeline control
  logic [cbe_pkg::NSTG-1:0] vld_r;
  logic                     en;
  logic                     in_acc;

  // stage 1: clamped parameter and its complement
  logic [cbe_pkg::T_W-1:0]   t_clamp, u_nxt;
  logic [cbe_pkg::T_W-1:0]   s1_t_r, s1_u_r;
  logic [cbe_pkg::ACT_W-1:0] s1_act_r;

  // stage 2: second-order products
  logic [cbe_pkg::SQ_W-1:0]  s2_tt_r, s2_tu_r, s2_uu_r;
  logic [cbe_pkg::T_W-1:0]   s2_t_r, s2_u_r;
  logic [cbe_pkg::ACT_W-1:0] s2_act_r;

  // stage 3: third-order products and first-derivative weights
  logic [cbe_pkg::CUBE_W-1:0] s3_uuu_r, s3_tuu_r, s3_ttu_r, s3_ttt_r;
  logic [cbe_pkg::DW_W-1:0]   dw0_sum, dw1_sum, dw2_sum;
  logic [cbe_pkg::WGT_W-1:0]  s3_dw0_r, s3_dw1_r, s3_dw2_r;
  logic [cbe_pkg::T_W-1:0]    s3_t_r, s3_u_r;
  logic [cbe_pkg::ACT_W-1:0]  s3_act_r;

  // stage 4: per-action coefficients shared by both axes
  logic [cbe_pkg::CUBE_W-1:0] r_uuu, r_tuu, r_ttu, r_ttt;
  logic signed [cbe_pkg::COEF_W-1:0] pw0, pw1, pw2, pw3;
  logic signed [cbe_pkg::COEF_W-1:0] dw0, dw1, dw2;
  logic signed [cbe_pkg::COEF_W-1:0] ts_c, us_c;
  cbe_pkg::coef_t coef_nxt, coef_r;

  logic signed [cbe_pkg::OUT_W-1:0] res_x, res_y;

  // ---------------------------------------------------------------- control
  assign en           = !vld_r[cbe_pkg::NSTG-1] || out_ch.ready;
  assign in_ch.ready  = rst_n && en;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[cbe_pkg::NSTG-2:0], in_ch.valid};
    end
  end

  // ---------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cbe_pkg::CFG_NUM; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_we) begin
      cfg_r[cfg_idx] <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // parameters above one are clamped to one
  assign t_clamp = (in_ch.t_param > cbe_pkg::ONE_Q16) ? cbe_pkg::ONE_Q16 : in_ch.t_param;
  assign u_nxt   = cbe_pkg::ONE_Q16 - t_clamp;

  // ---------------------------------------------------------------- stage 3
  // first-derivative weights 3u^2, 6ut, 3t^2 rounded from Q0.32 to Q0.24
  assign dw0_sum = cbe_pkg::DW_W'(s2_uu_r) * cbe_pkg::DW_W'(3) + cbe_pkg::RND8;
  assign dw1_sum = cbe_pkg::DW_W'(s2_tu_r) * cbe_pkg::DW_W'(6) + cbe_pkg::RND8;
  assign dw2_sum = cbe_pkg::DW_W'(s2_tt_r) * cbe_pkg::DW_W'(3) + cbe_pkg::RND8;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_t_r   <= t_clamp;
      s1_u_r   <= u_nxt;
      s1_act_r <= in_ch.action;

      s2_tt_r  <= cbe_pkg::SQ_W'(s1_t_r) * cbe_pkg::SQ_W'(s1_t_r);
      s2_tu_r  <= cbe_pkg::SQ_W'(s1_t_r) * cbe_pkg::SQ_W'(s1_u_r);
      s2_uu_r  <= cbe_pkg::SQ_W'(s1_u_r) * cbe_pkg::SQ_W'(s1_u_r);
      s2_t_r   <= s1_t_r;
      s2_u_r   <= s1_u_r;
      s2_act_r <= s1_act_r;

      s3_uuu_r <= cbe_pkg::CUBE_W'(s2_uu_r) * cbe_pkg::CUBE_W'(s2_u_r);
      s3_tuu_r <= cbe_pkg::CUBE_W'(s2_tu_r) * cbe_pkg::CUBE_W'(s2_u_r);
      s3_ttu_r <= cbe_pkg::CUBE_W'(s2_tu_r) * cbe_pkg::CUBE_W'(s2_t_r);
      s3_ttt_r <= cbe_pkg::CUBE_W'(s2_tt_r) * cbe_pkg::CUBE_W'(s2_t_r);
      s3_dw0_r <= dw0_sum[cbe_pkg::DW_W-2:8];
      s3_dw1_r <= dw1_sum[cbe_pkg::DW_W-2:8];
      s3_dw2_r <= dw2_sum[cbe_pkg::DW_W-2:8];
      s3_t_r   <= s2_t_r;
      s3_u_r   <= s2_u_r;
      s3_act_r <= s2_act_r;

      coef_r   <= coef_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // bernstein weights u^3, 3tu^2, 3t^2u, t^3 rounded from Q0.48 to Q0.24
  assign r_uuu = s3_uuu_r + cbe_pkg::RND24;
  assign r_tuu = s3_tuu_r * cbe_pkg::CUBE_W'(3) + cbe_pkg::RND24;
  assign r_ttu = s3_ttu_r * cbe_pkg::CUBE_W'(3) + cbe_pkg::RND24;
  assign r_ttt = s3_ttt_r + cbe_pkg::RND24;

  assign pw0  = cbe_pkg::COEF_W'(r_uuu[cbe_pkg::CUBE_W-1:24]);
  assign pw1  = cbe_pkg::COEF_W'(r_tuu[cbe_pkg::CUBE_W-1:24]);
  assign pw2  = cbe_pkg::COEF_W'(r_ttu[cbe_pkg::CUBE_W-1:24]);
  assign pw3  = cbe_pkg::COEF_W'(r_ttt[cbe_pkg::CUBE_W-1:24]);
  assign dw0  = cbe_pkg::COEF_W'(s3_dw0_r);
  assign dw1  = cbe_pkg::COEF_W'(s3_dw1_r);
  assign dw2  = cbe_pkg::COEF_W'(s3_dw2_r);
  assign ts_c = cbe_pkg::COEF_W'(s3_t_r);
  assign us_c = cbe_pkg::COEF_W'(s3_u_r);

  // everything is brought to a common divisor of 5*2^24, so the second
  // derivative (divisor 5*2^16) carries an extra factor of 256
  always_comb begin
    coef_nxt = '0;
    case (s3_act_r)
      cbe_pkg::ACT_POINT: begin
        coef_nxt.a = pw0 + pw1;
        coef_nxt.b = pw2 + pw3;
        coef_nxt.c = pw1;
        coef_nxt.d = -pw2;
      end
      cbe_pkg::ACT_DERIV1: begin
        coef_nxt.a = -dw1;
        coef_nxt.b = dw1;
        coef_nxt.c = dw0 - dw1;
        coef_nxt.d = dw2 - dw1;
      end
      cbe_pkg::ACT_DERIV2: begin
        coef_nxt.a = (ts_c - us_c) * cbe_pkg::COEF_W'(1536);
        coef_nxt.b = (us_c - ts_c) * cbe_pkg::COEF_W'(1536);
        coef_nxt.c = (ts_c * cbe_pkg::COEF_W'(6) - us_c * cbe_pkg::COEF_W'(12)) <<< 8;
        coef_nxt.d = (ts_c * cbe_pkg::COEF_W'(12) - us_c * cbe_pkg::COEF_W'(6)) <<< 8;
      end
      default: begin
        // unused action code gives a zero result on both axes
        coef_nxt = '0;
      end
    endcase
  end

  // ------------------------------------------------------- stages 5 to 13
  cbe_axis u_axis_x (
    .clk  (clk),
    .en   (en),
    .coef (coef_r),
    .p0   (cfg_r[cbe_pkg::CFG_START_X]),
    .p3   (cfg_r[cbe_pkg::CFG_END_X]),
    .ts   (cfg_r[cbe_pkg::CFG_START_TAN_X]),
    .te   (cfg_r[cbe_pkg::CFG_END_TAN_X]),
    .res  (res_x)
  );

  cbe_axis u_axis_y (
    .clk  (clk),
    .en   (en),
    .coef (coef_r),
    .p0   (cfg_r[cbe_pkg::CFG_START_Y]),
    .p3   (cfg_r[cbe_pkg::CFG_END_Y]),
    .ts   (cfg_r[cbe_pkg::CFG_START_TAN_Y]),
    .te   (cfg_r[cbe_pkg::CFG_END_TAN_Y]),
    .res  (res_y)
  );

  assign out_ch.valid = vld_r[cbe_pkg::NSTG-1];
  assign out_ch.out_x = res_x;
  assign out_ch.out_y = res_y;

  // ------------------------------------------------------------- assertions
  // a result held at the output blocks new items
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("item accepted while output stalled");

  // an accepted item shows up in the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> vld_r[0])
    else $error("accepted item lost at stage one");

  // a frozen pipe neither gains nor drops items
  a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid bits moved during stall");

  // clamped parameter and complement add up to one
  a_clamp_sum: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (s1_t_r <= cbe_pkg::ONE_Q16) &&
               ((cbe_pkg::T_W + 1)'(s1_t_r) + (cbe_pkg::T_W + 1)'(s1_u_r) ==
                (cbe_pkg::T_W + 1)'(cbe_pkg::ONE_Q16)))
    else $error("parameter clamp broken");

  // unused action code leaves all coefficients zero
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[2] && s3_act_r != cbe_pkg::ACT_POINT &&
    s3_act_r != cbe_pkg::ACT_DERIV1 && s3_act_r != cbe_pkg::ACT_DERIV2
    |=> coef_r == '0)
    else $error("unused action gave nonzero coefficients");

endmodule

`default_nettype wire
